>>> hdl/qrs_pkg.sv
// Shared constants and types of the quadratic root solver.
`default_nettype none

package qrs_pkg;

  // Default word format: signed Q16.16
  localparam int unsigned WORD_BITS_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Kind of solution reported with each result word
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_ONE  = 2'd1,
    KIND_TWO  = 2'd2,
    KIND_ALL  = 2'd3
  } kind_e;

endpackage

`default_nettype wire

>>> hdl/qrs_coef_if.sv
// Coefficient channel: valid/ready handshake carrying a, b and c.
`default_nettype none

interface qrs_coef_if #(
  parameter int unsigned WORD_BITS = qrs_pkg::WORD_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] coef_a;
  logic signed [WORD_BITS-1:0] coef_b;
  logic signed [WORD_BITS-1:0] coef_c;

  modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
  modport sink   (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

`default_nettype wire

>>> hdl/qrs_root_if.sv
// Result channel: valid/ready handshake carrying the solution kind and roots.
`default_nettype none

interface qrs_root_if #(
  parameter int unsigned WORD_BITS = qrs_pkg::WORD_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  qrs_pkg::kind_e              solution_kind;
  logic signed [WORD_BITS-1:0] root_plus;
  logic signed [WORD_BITS-1:0] root_minus;
  logic                        saturated;

  modport source (output valid, output solution_kind, output root_plus,
                  output root_minus, output saturated, input ready);
  modport sink   (input valid, input solution_kind, input root_plus,
                  input root_minus, input saturated, output ready);
endinterface

`default_nettype wire

>>> hdl/qrs_sqrt_cell.sv
// One restoring square-root step: brings down two radicand bits, yields one root bit.
`default_nettype none

module qrs_sqrt_cell #(
  parameter int unsigned RAD_W  = 4,
  parameter int unsigned ROOT_W = 2,
  parameter int unsigned SIDE_W = 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              vld_i,
  input  wire logic [RAD_W-1:0]  rad_i,
  input  wire logic [ROOT_W+2:0] rem_i,
  input  wire logic [ROOT_W-1:0] root_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   vld_o,
  output logic [RAD_W-1:0]       rad_o,
  output logic [ROOT_W+2:0]      rem_o,
  output logic [ROOT_W-1:0]      root_o,
  output logic [SIDE_W-1:0]      side_o
);
  localparam int unsigned REM_W = ROOT_W + 3;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             ge;
  logic [REM_W-1:0] rem_d;

  // trial subtract of 4*root+1 from the shifted remainder
  always_comb begin
    rem_sh = {rem_i[REM_W-3:0], rad_i[RAD_W-1 -: 2]};
    trial  = REM_W'({root_i, 2'b01});
    ge     = (rem_sh >= trial);
    rem_d  = ge ? (rem_sh - trial) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_o  <= rad_i << 2;
      rem_o  <= rem_d;
      root_o <= {root_i[ROOT_W-2:0], ge};
      side_o <= side_i;
    end
  end

endmodule

`default_nettype wire

>>> hdl/qrs_div_cell.sv
// One restoring division step: brings down one dividend bit, yields one quotient bit.
`default_nettype none

module qrs_div_cell #(
  parameter int unsigned DVD_W  = 2,
  parameter int unsigned DEN_W  = 2,
  parameter int unsigned SIDE_W = 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              vld_i,
  input  wire logic [DVD_W-1:0]  dvd_i,
  input  wire logic [DEN_W:0]    rem_i,
  input  wire logic [DEN_W-1:0]  den_i,
  input  wire logic [DVD_W-1:0]  quo_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   vld_o,
  output logic [DVD_W-1:0]       dvd_o,
  output logic [DEN_W:0]         rem_o,
  output logic [DEN_W-1:0]       den_o,
  output logic [DVD_W-1:0]       quo_o,
  output logic [SIDE_W-1:0]      side_o
);
  localparam int unsigned REM_W = DEN_W + 1;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] den_x;
  logic             ge;
  logic [REM_W-1:0] rem_d;

  // compare and subtract against the divisor
  always_comb begin
    rem_sh = {rem_i[REM_W-2:0], dvd_i[DVD_W-1]};
    den_x  = REM_W'(den_i);
    ge     = (rem_sh >= den_x);
    rem_d  = ge ? (rem_sh - den_x) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dvd_o  <= dvd_i << 1;
      rem_o  <= rem_d;
      den_o  <= den_i;
      quo_o  <= {quo_i[DVD_W-2:0], ge};
      side_o <= side_i;
    end
  end

endmodule

`default_nettype wire

>>> hdl/quadratic_root_solver.sv
// Top level of the quadratic root solver: multiply, discriminant, sqrt row, divider rows.
//
// Takes one coefficient word (a, b, c in signed fixed point, Q16.16 by default) per cycle and
// returns one result word per input, in order: the solution kind and up to two roots rounded
// to nearest, clipped to the word range with the saturated flag. The data path is a fixed
// pipeline: two stages form b*b, a*c and the discriminant, a row of WORD_BITS+FRAC_BITS+1
// square-root cells follows, two stages build rounded dividends, and two parallel rows of
// WORD_BITS divider cells finish. The sustained rate is one word per cycle while the output
// buffer has room. A two-entry output buffer keeps the input open while one result waits;
// the whole pipeline holds when that buffer is full.
`default_nettype none

module quadratic_root_solver #(
  parameter int unsigned WORD_BITS = qrs_pkg::WORD_BITS_DEF,
  parameter int unsigned FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  qrs_coef_if.sink        coef_i,
  qrs_root_if.source      root_o
);
  localparam int unsigned W   = WORD_BITS;
  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned DW  = 2*W + 2;      // signed discriminant
  localparam int unsigned DMW = 2*W + 1;      // discriminant magnitude
  localparam int unsigned SQ  = W + F + 1;    // root bits
  localparam int unsigned RE  = 2*SQ;         // radicand bits
  localparam int unsigned RMW = SQ + 3;       // sqrt remainder
  localparam int unsigned NSW = W + F + 3;    // signed numerator
  localparam int unsigned NMW = W + F + 2;    // numerator magnitude
  localparam int unsigned XW  = W + F + 4;    // rounded dividend
  localparam int unsigned YW  = W + 2;        // signed denominator / doubled divisor
  localparam int unsigned RMD = YW + 1;       // divider remainder
  localparam int unsigned CW  = 2*W + F + 4;  // overflow compare width

  localparam logic [W-1:0] HALF = {1'b1, {(W-1){1'b0}}};

  // side data through the sqrt row
  typedef struct packed {
    logic                  az;
    logic                  bz;
    logic                  cz;
    logic                  dneg;
    logic                  dzero;
    logic signed [NSW-1:0] nb;
    logic signed [NSW-1:0] lnum;
    logic signed [W-1:0]   b;
    logic signed [YW-1:0]  den2a;
  } sq_side_t;

  typedef struct packed {
    qrs_pkg::kind_e kind;
    logic           neg;
    logic           ovf;
  } dp_side_t;

  typedef struct packed {
    logic neg;
    logic ovf;
  } dm_side_t;

  typedef struct packed {
    logic [XW-1:0] x;
    logic [YW-1:0] y;
    logic          neg;
  } lane_t;

  typedef struct packed {
    qrs_pkg::kind_e       kind;
    logic signed [W-1:0]  rp;
    logic signed [W-1:0]  rm;
    logic                 sat;
  } out_t;

  localparam int unsigned SQS_W = $bits(sq_side_t);
  localparam int unsigned DPS_W = $bits(dp_side_t);
  localparam int unsigned DMS_W = $bits(dm_side_t);

  // rounded magnitude division setup: (2|n| + |d|) / (2|d|)
  function automatic lane_t lane_prep(logic signed [NSW-1:0] num, logic signed [YW-1:0] den);
    lane_t            l;
    logic [NMW-1:0]   nmag;
    logic [YW-2:0]    dmag;
    nmag  = NMW'(num[NSW-1] ? -num : num);
    dmag  = (YW-1)'(den[YW-1] ? -den : den);
    l.x   = (XW'(nmag) << 1) + XW'(dmag);
    l.y   = YW'(dmag) << 1;
    l.neg = num[NSW-1] ^ den[YW-1];
    return l;
  endfunction

  logic en;
  logic push;
  logic pop;

  // ---------------- stage 1: products ----------------
  logic                  p1_vld_q;
  logic signed [W-1:0]   p1_a_q, p1_b_q, p1_c_q;
  logic signed [2*W-1:0] p1_bb_q, p1_ac_q;
  logic signed [2*W-1:0] p1_bb_d, p1_ac_d;

  always_comb begin
    p1_bb_d = coef_i.coef_b * coef_i.coef_b;
    p1_ac_d = coef_i.coef_a * coef_i.coef_c;
  end

  // ---------------- stage 2: discriminant ----------------
  logic                  p2_vld_q;
  sq_side_t              p2_side_q, p2_side_d;
  logic [DMW-1:0]        p2_dmag_q;
  logic signed [DW-1:0]  disc;

  always_comb begin
    disc              = DW'(p1_bb_q) - (DW'(p1_ac_q) <<< 2);
    p2_side_d.az      = (p1_a_q == '0);
    p2_side_d.bz      = (p1_b_q == '0);
    p2_side_d.cz      = (p1_c_q == '0);
    p2_side_d.dneg    = disc[DW-1];
    p2_side_d.dzero   = (disc == '0);
    p2_side_d.nb      = -(NSW'(p1_b_q) <<< F);
    p2_side_d.lnum    = -(NSW'(p1_c_q) <<< F);
    p2_side_d.b       = p1_b_q;
    p2_side_d.den2a   = YW'(p1_a_q) <<< 1;
  end

  // ---------------- square-root row ----------------
  logic             sq_vld  [SQ+1];
  logic [RE-1:0]    sq_rad  [SQ+1];
  logic [RMW-1:0]   sq_rem  [SQ+1];
  logic [SQ-1:0]    sq_root [SQ+1];
  logic [SQS_W-1:0] sq_side [SQ+1];

  assign sq_vld[0]  = p2_vld_q;
  assign sq_rad[0]  = RE'(p2_dmag_q) << (2*F);
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = p2_side_q;

  for (genvar i = 0; i < SQ; i++) begin : g_sqrt
    qrs_sqrt_cell #(
      .RAD_W  (RE),
      .ROOT_W (SQ),
      .SIDE_W (SQS_W)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (sq_vld[i]),
      .rad_i  (sq_rad[i]),
      .rem_i  (sq_rem[i]),
      .root_i (sq_root[i]),
      .side_i (sq_side[i]),
      .vld_o  (sq_vld[i+1]),
      .rad_o  (sq_rad[i+1]),
      .rem_o  (sq_rem[i+1]),
      .root_o (sq_root[i+1]),
      .side_o (sq_side[i+1])
    );
  end

  // ---------------- stage 3: numerators, denominators, kind ----------------
  sq_side_t              sq_end;
  logic signed [NSW-1:0] sroot;
  logic                  lin;

  logic                  p3_vld_q;
  qrs_pkg::kind_e        p3_kind_q, p3_kind_d;
  logic signed [NSW-1:0] p3_nump_q, p3_numm_q, p3_nump_d, p3_numm_d;
  logic signed [YW-1:0]  p3_denp_q, p3_denm_q, p3_denp_d, p3_denm_d;

  always_comb begin
    sq_end    = sq_side_t'(sq_side[SQ]);
    sroot     = $signed(NSW'(sq_root[SQ]));
    lin       = sq_end.az && !sq_end.bz;
    p3_nump_d = lin ? sq_end.lnum : (sq_end.nb + sroot);
    p3_numm_d = sq_end.nb - sroot;
    p3_denp_d = lin ? YW'(sq_end.b) : sq_end.den2a;
    p3_denm_d = sq_end.den2a;
    // keep the divisors nonzero where no root is reported
    if (p3_denp_d == '0) begin
      p3_denp_d = YW'(1);
    end
    if (p3_denm_d == '0) begin
      p3_denm_d = YW'(1);
    end
    if (sq_end.az) begin
      if (sq_end.bz) begin
        p3_kind_d = sq_end.cz ? qrs_pkg::KIND_ALL : qrs_pkg::KIND_NONE;
      end else begin
        p3_kind_d = qrs_pkg::KIND_ONE;
      end
    end else if (sq_end.dneg) begin
      p3_kind_d = qrs_pkg::KIND_NONE;
    end else if (sq_end.dzero) begin
      p3_kind_d = qrs_pkg::KIND_ONE;
    end else begin
      p3_kind_d = qrs_pkg::KIND_TWO;
    end
  end

  // ---------------- stage 4: rounded dividends ----------------
  logic           p4_vld_q;
  qrs_pkg::kind_e p4_kind_q;
  lane_t          p4_lp_q, p4_lm_q;

  // ---------------- divider rows ----------------
  logic [CW-1:0]    xp_ext, xm_ext;
  logic             ovfp, ovfm;
  dp_side_t         dp_side0;
  dm_side_t         dm_side0;

  always_comb begin
    xp_ext         = CW'(p4_lp_q.x);
    xm_ext         = CW'(p4_lm_q.x);
    ovfp           = (xp_ext >= (CW'(p4_lp_q.y) << W));
    ovfm           = (xm_ext >= (CW'(p4_lm_q.y) << W));
    dp_side0.kind  = p4_kind_q;
    dp_side0.neg   = p4_lp_q.neg;
    dp_side0.ovf   = ovfp;
    dm_side0.neg   = p4_lm_q.neg;
    dm_side0.ovf   = ovfm;
  end

  logic             dp_vld  [W+1];
  logic [W-1:0]     dp_dvd  [W+1];
  logic [RMD-1:0]   dp_rem  [W+1];
  logic [YW-1:0]    dp_den  [W+1];
  logic [W-1:0]     dp_quo  [W+1];
  logic [DPS_W-1:0] dp_side [W+1];

  logic             dm_vld  [W+1];
  logic [W-1:0]     dm_dvd  [W+1];
  logic [RMD-1:0]   dm_rem  [W+1];
  logic [YW-1:0]    dm_den  [W+1];
  logic [W-1:0]     dm_quo  [W+1];
  logic [DMS_W-1:0] dm_side [W+1];

  assign dp_vld[0]  = p4_vld_q;
  assign dp_dvd[0]  = p4_lp_q.x[W-1:0];
  assign dp_rem[0]  = RMD'(xp_ext >> W);
  assign dp_den[0]  = p4_lp_q.y;
  assign dp_quo[0]  = '0;
  assign dp_side[0] = dp_side0;

  assign dm_vld[0]  = p4_vld_q;
  assign dm_dvd[0]  = p4_lm_q.x[W-1:0];
  assign dm_rem[0]  = RMD'(xm_ext >> W);
  assign dm_den[0]  = p4_lm_q.y;
  assign dm_quo[0]  = '0;
  assign dm_side[0] = dm_side0;

  for (genvar i = 0; i < W; i++) begin : g_div
    qrs_div_cell #(
      .DVD_W  (W),
      .DEN_W  (YW),
      .SIDE_W (DPS_W)
    ) u_plus (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (dp_vld[i]),
      .dvd_i  (dp_dvd[i]),
      .rem_i  (dp_rem[i]),
      .den_i  (dp_den[i]),
      .quo_i  (dp_quo[i]),
      .side_i (dp_side[i]),
      .vld_o  (dp_vld[i+1]),
      .dvd_o  (dp_dvd[i+1]),
      .rem_o  (dp_rem[i+1]),
      .den_o  (dp_den[i+1]),
      .quo_o  (dp_quo[i+1]),
      .side_o (dp_side[i+1])
    );

    qrs_div_cell #(
      .DVD_W  (W),
      .DEN_W  (YW),
      .SIDE_W (DMS_W)
    ) u_minus (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (dm_vld[i]),
      .dvd_i  (dm_dvd[i]),
      .rem_i  (dm_rem[i]),
      .den_i  (dm_den[i]),
      .quo_i  (dm_quo[i]),
      .side_i (dm_side[i]),
      .vld_o  (dm_vld[i+1]),
      .dvd_o  (dm_dvd[i+1]),
      .rem_o  (dm_rem[i+1]),
      .den_o  (dm_den[i+1]),
      .quo_o  (dm_quo[i+1]),
      .side_o (dm_side[i+1])
    );
  end

  // ---------------- final: clip, sign and select ----------------
  dp_side_t     dp_end;
  dm_side_t     dm_end;
  logic [W-1:0] qp, qm;
  logic         satp, satm;
  logic [W-1:0] rootp, rootm;
  logic         rep1, rep2;
  out_t         out_d;

  always_comb begin
    dp_end = dp_side_t'(dp_side[W]);
    dm_end = dm_side_t'(dm_side[W]);
    qp     = dp_quo[W];
    qm     = dm_quo[W];
    satp   = dp_end.ovf || (qp > (dp_end.neg ? HALF : HALF - W'(1)));
    satm   = dm_end.ovf || (qm > (dm_end.neg ? HALF : HALF - W'(1)));
    rootp  = satp ? (dp_end.neg ? HALF : HALF - W'(1)) : (dp_end.neg ? -qp : qp);
    rootm  = satm ? (dm_end.neg ? HALF : HALF - W'(1)) : (dm_end.neg ? -qm : qm);
    rep2   = (dp_end.kind == qrs_pkg::KIND_TWO);
    rep1   = rep2 || (dp_end.kind == qrs_pkg::KIND_ONE);
    out_d.kind = dp_end.kind;
    out_d.rp   = rep1 ? $signed(rootp) : '0;
    out_d.rm   = rep2 ? $signed(rootm) : '0;
    out_d.sat  = (rep1 && satp) || (rep2 && satm);
  end

  // ---------------- front pipeline registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
      p3_vld_q <= 1'b0;
      p4_vld_q <= 1'b0;
    end else if (en) begin
      p1_vld_q <= coef_i.valid;
      p2_vld_q <= p1_vld_q;
      p3_vld_q <= sq_vld[SQ];
      p4_vld_q <= p3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_a_q    <= coef_i.coef_a;
      p1_b_q    <= coef_i.coef_b;
      p1_c_q    <= coef_i.coef_c;
      p1_bb_q   <= p1_bb_d;
      p1_ac_q   <= p1_ac_d;
      p2_side_q <= p2_side_d;
      p2_dmag_q <= disc[DMW-1:0];
      p3_kind_q <= p3_kind_d;
      p3_nump_q <= p3_nump_d;
      p3_numm_q <= p3_numm_d;
      p3_denp_q <= p3_denp_d;
      p3_denm_q <= p3_denm_d;
      p4_kind_q <= p3_kind_q;
      p4_lp_q   <= lane_prep(p3_nump_q, p3_denp_q);
      p4_lm_q   <= lane_prep(p3_numm_q, p3_denm_q);
    end
  end

  // ---------------- two-entry output buffer ----------------
  out_t       buf_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;

  assign en   = (cnt_q != 2'd2);
  assign push = en && dp_vld[W] && dm_vld[W];
  assign pop  = root_o.valid && root_o.ready;

  assign coef_i.ready = en;

  always_comb begin
    cnt_d = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= out_d;
    end
  end

  assign root_o.valid         = (cnt_q != 2'd0);
  assign root_o.solution_kind = buf_q[rd_ptr_q].kind;
  assign root_o.root_plus     = buf_q[rd_ptr_q].rp;
  assign root_o.root_minus    = buf_q[rd_ptr_q].rm;
  assign root_o.saturated     = buf_q[rd_ptr_q].sat;

  // ---------------- assertions ----------------
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("output buffer count out of range");

  a_no_accept_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |=> (cnt_q != 2'd0) || $past(pop))
    else $error("output buffer lost a word");

  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_vld[W] == dm_vld[W])
    else $error("divider rows out of step");

  a_no_root_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_o.valid && (root_o.solution_kind == qrs_pkg::KIND_NONE ||
                     root_o.solution_kind == qrs_pkg::KIND_ALL)
    |-> root_o.root_plus == '0 && root_o.root_minus == '0 && !root_o.saturated)
    else $error("roots reported without a real solution");

  a_one_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_o.valid && root_o.solution_kind == qrs_pkg::KIND_ONE |-> root_o.root_minus == '0)
    else $error("second root reported for a single solution");

endmodule

`default_nettype wire

>>> tb/sv/qrs_checker.sv
// Result checker of the quadratic root solver: predicts each result word and compares it.
`default_nettype none

module qrs_checker (
  input  wire logic clk_i,
  qrs_coef_if       coef,
  qrs_root_if       root,
  output int        err_count_o,
  output int        pending_o,
  output int        result_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WB = qrs_pkg::WORD_BITS_DEF;
  localparam int unsigned FB = qrs_pkg::FRAC_BITS_DEF;

  typedef struct packed {
    qrs_pkg::kind_e       kind;
    logic signed [WB-1:0] rp;
    logic signed [WB-1:0] rm;
    logic                 sat;
  } roots_t;

  roots_t expected_roots[$];
  int     err_count    = 0;
  int     result_count = 0;

  assign err_count_o    = err_count;
  assign pending_o      = expected_roots.size();
  assign result_count_o = result_count;

  // Floor square root of a wide unsigned value
  function automatic logic [127:0] isqrt(input logic [127:0] n);
    logic [127:0] r;
    logic [127:0] t;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      t = r | (128'd1 << k);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  // Quotient rounded half away from zero, clipped to the word range
  function automatic logic [WB-1:0] round_div(input logic signed [127:0] n,
                                              input logic signed [127:0] d,
                                              inout logic sat);
    logic [127:0] na;
    logic [127:0] da;
    logic [127:0] q;
    logic [127:0] lim;
    logic         neg;
    na  = (n < 0) ? -n : n;
    da  = (d < 0) ? -d : d;
    q   = (2 * na + da) / (2 * da);
    neg = (q != 0) && ((n < 0) != (d < 0));
    lim = neg ? (128'd1 << (WB - 1)) : ((128'd1 << (WB - 1)) - 1);
    if (q > lim) begin
      q   = lim;
      sat = 1'b1;
    end
    return neg ? WB'(-q) : WB'(q);
  endfunction

  // Solve one coefficient set
  function automatic roots_t solve_roots(input logic signed [WB-1:0] a,
                                         input logic signed [WB-1:0] b,
                                         input logic signed [WB-1:0] c);
    roots_t              res;
    logic signed [127:0] sa;
    logic signed [127:0] sb;
    logic signed [127:0] sc;
    logic signed [127:0] disc;
    logic signed [127:0] nb;
    logic signed [127:0] den;
    logic signed [127:0] s;
    logic                sat;
    sa  = a;
    sb  = b;
    sc  = c;
    sat = 1'b0;
    res = '0;
    res.kind = qrs_pkg::KIND_NONE;
    if (sa == 0) begin
      if (sb == 0) begin
        res.kind = (sc == 0) ? qrs_pkg::KIND_ALL : qrs_pkg::KIND_NONE;
      end else begin
        res.kind = qrs_pkg::KIND_ONE;
        res.rp   = round_div(-(sc <<< FB), sb, sat);
      end
    end else begin
      disc = sb * sb - 4 * sa * sc;
      nb   = -(sb <<< FB);
      den  = 2 * sa;
      if (disc == 0) begin
        res.kind = qrs_pkg::KIND_ONE;
        res.rp   = round_div(nb, den, sat);
      end else if (disc > 0) begin
        s        = isqrt(disc << (2 * FB));
        res.kind = qrs_pkg::KIND_TWO;
        res.rp   = round_div(nb + s, den, sat);
        res.rm   = round_div(nb - s, den, sat);
      end
    end
    res.sat = sat;
    return res;
  endfunction

  // Predict on accepted coefficients, compare on accepted results
  always @(posedge clk_i) begin
    roots_t exp_r;
    if (coef.valid && coef.ready)
      expected_roots.push_back(solve_roots(coef.coef_a, coef.coef_b, coef.coef_c));
    if (root.valid && root.ready) begin
      result_count++;
      if (expected_roots.size() == 0) begin
        err_count++;
        $display("%0t: result word with nothing expected: kind %0d", $realtime,
                 root.solution_kind);
      end else begin
        exp_r = expected_roots.pop_front();
        if (root.solution_kind !== exp_r.kind) begin
          err_count++;
          $display("%0t: kind expected %0d actual %0d", $realtime, exp_r.kind,
                   root.solution_kind);
        end
        if (root.root_plus !== exp_r.rp) begin
          err_count++;
          $display("%0t: root_plus expected %h actual %h", $realtime, exp_r.rp,
                   root.root_plus);
        end
        if (root.root_minus !== exp_r.rm) begin
          err_count++;
          $display("%0t: root_minus expected %h actual %h", $realtime, exp_r.rm,
                   root.root_minus);
        end
        if (root.saturated !== exp_r.sat) begin
          err_count++;
          $display("%0t: saturated expected %b actual %b", $realtime, exp_r.sat,
                   root.saturated);
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// Top of the quadratic root solver testbench: clock, reset, stimulus and verdict.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WB         = qrs_pkg::WORD_BITS_DEF;
  localparam int          N_RANDOM   = 500;
  localparam int          LATENCY    = 2 * WB + qrs_pkg::FRAC_BITS_DEF + 6;
  localparam int          CYCLE_LIMIT = 200000;

  logic clk_i;
  logic rst_ni;
  int   cycle_cnt = 0;
  int   err_count;
  int   pending;
  int   result_count;
  int   sent_count = 0;

  qrs_coef_if #(.WORD_BITS(WB)) coef_bus ();
  qrs_root_if #(.WORD_BITS(WB)) root_bus ();

  quadratic_root_solver u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .coef_i (coef_bus),
    .root_o (root_bus)
  );

  qrs_checker u_checker (
    .clk_i          (clk_i),
    .coef           (coef_bus),
    .root           (root_bus),
    .err_count_o    (err_count),
    .pending_o      (pending),
    .result_count_o (result_count)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Cycle counter and timeout
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result sink: random stalls, one long hold-off, one stretch always ready
  initial begin
    int hold;
    root_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (cycle_cnt == 400) begin
        for (hold = 0; hold < 300; hold++) begin
          root_bus.ready <= 1'b0;
          @(posedge clk_i);
        end
      end
      if (cycle_cnt > 900 && cycle_cnt < 1200) root_bus.ready <= 1'b1;
      else root_bus.ready <= ($urandom_range(0, 99) >= 37);
    end
  end

  // Random coefficient set, mostly shaped toward small values, real roots or degenerate cases
  function automatic logic [3*WB-1:0] random_coefs();
    logic signed [WB-1:0] a;
    logic signed [WB-1:0] b;
    logic signed [WB-1:0] c;
    int                   m;
    int                   n;
    int                   mode;
    mode = $urandom_range(0, 99);
    a = $urandom();
    b = $urandom();
    c = $urandom();
    if (mode < 30) begin
      a = $signed(a) >>> $urandom_range(8, 30);
      b = $signed(b) >>> $urandom_range(4, 20);
      c = $signed(c) >>> $urandom_range(4, 30);
      if (a == 0) a = 1;
    end else if (mode < 45) begin
      // zero discriminant: a = m^2, c = n^2, b = +/-2mn (2mn kept inside the word)
      m = $urandom_range(1, 32000);
      n = $urandom_range(0, 32000);
      if ($urandom_range(0, 1)) m = -m;
      a = m * m;
      c = n * n;
      b = 2 * m * n;
      if ($urandom_range(0, 1)) begin
        a = -a;
        c = -c;
      end
    end else if (mode < 60) begin
      // two roots: a and c of opposite signs
      a = ($signed(a) >>> $urandom_range(4, 28)) | 1;
      c = $signed(c) >>> $urandom_range(0, 20);
      if ((a < 0) == (c < 0)) c = -c;
    end else if (mode < 70) begin
      a = '0;
      b = $signed(b) >>> $urandom_range(0, 24);
    end else if (mode < 74) begin
      a = '0;
      b = '0;
      if ($urandom_range(0, 1)) c = '0;
    end
    return {a, b, c};
  endfunction

  // Offer one word and wait for its acceptance, with a random gap before it unless no_gap is set
  task automatic send_coefs(input logic [3*WB-1:0] abc, input bit no_gap);
    if (!no_gap) begin
      while ($urandom_range(0, 99) < 37) begin
        coef_bus.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    coef_bus.valid  <= 1'b1;
    coef_bus.coef_a <= abc[3*WB-1:2*WB];
    coef_bus.coef_b <= abc[2*WB-1:WB];
    coef_bus.coef_c <= abc[WB-1:0];
    do @(posedge clk_i); while (!coef_bus.ready);
    sent_count++;
  endtask

  // Stimulus and verdict
  initial begin
    logic [3*WB-1:0] directed[$];
    int              wait_cnt;
    coef_bus.valid  <= 1'b0;
    coef_bus.coef_a <= '0;
    coef_bus.coef_b <= '0;
    coef_bus.coef_c <= '0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every x, no root, linear, extremes, discriminant signs, saturation
    directed = '{
      {32'h0, 32'h0, 32'h0},
      {32'h0, 32'h0, 32'h0001_0000},
      {32'h0, 32'h0, 32'h8000_0000},
      {32'h0, 32'h0001_0000, 32'hfffe_0000},
      {32'h0, 32'h0000_0001, 32'h7fff_ffff},
      {32'h0, 32'hffff_ffff, 32'h8000_0000},
      {32'h0, 32'h8000_0000, 32'h8000_0000},
      {32'h0001_0000, 32'h0, 32'h0001_0000},
      {32'h0001_0000, 32'h0, 32'hffff_0000},
      {32'h0001_0000, 32'h0002_0000, 32'h0001_0000},
      {32'h0001_0000, 32'h0, 32'h0},
      {32'h0000_0001, 32'h7fff_ffff, 32'h0},
      {32'h0000_0001, 32'h8000_0000, 32'h0},
      {32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff},
      {32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
      {32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff},
      {32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000},
      {32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff},
      {32'h0000_0001, 32'h0000_0001, 32'h8000_0000},
      {32'hffff_0000, 32'h0003_0000, 32'h0004_0000}
    };
    foreach (directed[i]) send_coefs(directed[i], 1'b0);
    for (int i = 0; i < N_RANDOM; i++)
      send_coefs(random_coefs(), (i > 200 && i < 300));
    coef_bus.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    for (wait_cnt = 0; wait_cnt < 2 * LATENCY; wait_cnt++) @(posedge clk_i);

    $display("sent %0d coefficient words, checked %0d result words,", sent_count,
             result_count);
    $display("covering all solution kinds, extremes and a long output stall");
    if (err_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> quadratic_root_solver.f
hdl/qrs_pkg.sv
hdl/qrs_coef_if.sv
hdl/qrs_root_if.sv
hdl/qrs_sqrt_cell.sv
hdl/qrs_div_cell.sv
hdl/quadratic_root_solver.sv
tb/sv/qrs_checker.sv
tb/sv/tb_top.sv
